[rtl/incast_window_clamp_engine_core_macros.svh]
// ----------------------------------------------------------------------------
// incast_window_clamp_engine_core_macros
// Assertion macros shared by the incast window clamp engine.
// ----------------------------------------------------------------------------
`ifndef INCAST_WINDOW_CLAMP_ENGINE_CORE_MACROS_SVH
`define INCAST_WINDOW_CLAMP_ENGINE_CORE_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define IWC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define IWC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[rtl/iwce_pkg.sv]
// ----------------------------------------------------------------------------
// iwce_pkg
// Types and constants of the incast window clamp engine.
// ----------------------------------------------------------------------------
package iwce_pkg;

	localparam logic [1:0] REQ_PACKET   = 2'd0;
	localparam logic [1:0] REQ_TICK     = 2'd1;
	localparam logic [1:0] REQ_SETUP    = 2'd2;
	localparam logic [1:0] REQ_RESERVED = 2'd3;

	localparam logic [1:0] CFG_ENABLE      = 2'd0;
	localparam logic [1:0] CFG_ROUND_LIMIT = 2'd1;
	localparam logic [1:0] CFG_HOLD_ROUNDS = 2'd2;

	localparam logic [15:0] HDR_OVERHEAD = 16'd54;
	localparam int WND_SHIFT = 3;

	// One input item as it passes from the front part to the back part.
	typedef struct packed {
		logic [1:0]  req_type;
		logic [3:0]  port;
		logic        is_tcp;
		logic        syn_flag;
		logic        fin_flag;
		logic        ack_flag;
		logic [15:0] window_in;
		logic [15:0] checksum_in;
		logic [23:0] backlog;
		logic        last_port;
		logic [23:0] queue_limit_in;
		logic [15:0] mtu_in;
	} item_t;

	// Result item.
	typedef struct packed {
		logic [15:0] window_out;
		logic [15:0] checksum_out;
		logic        window_rewritten;
		logic        incast_state;
		logic        incast_detected;
		logic        accepted;
	} result_t;

	// Incremental one's complement checksum update.
	function automatic logic [15:0] csum_patch(logic [15:0] hc, logic [15:0] oldv,
			logic [15:0] newv);
		logic [17:0] s;
		logic [16:0] t;
		begin
			s = {2'b0, ~hc} + {2'b0, ~oldv} + {2'b0, newv};
			t = {1'b0, s[15:0]} + {15'b0, s[17:16]};
			t = {1'b0, t[15:0]} + {16'b0, t[16]};
			csum_patch = ~t[15:0];
		end
	endfunction

endpackage

[rtl/incast_window_clamp_engine_core.sv]
// ----------------------------------------------------------------------------
// incast_window_clamp_engine_core
// Per-port incast detector with TCP window clamp.
// ----------------------------------------------------------------------------
// Usage: items enter on the in channel (in_valid/in_stall) as separate field
// ports; one result leaves per item on the out channel (out_valid/out_stall).
// Registers enable, round_limit and hold_rounds are written through the
// cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data); the user must write
// them only while idle, which the block does not enforce. A two-entry queue
// separates input acceptance from execution, so input keeps flowing while a
// result waits at the output register. Each item passes a queue entry and
// the output register; a tick on a set-up port first waits at the queue head
// while its syn count times clamped window product is registered. Throughput:
// one packet or setup per cycle while the output is free.
// Reset clears all port entries, incast flags, syn counts and the round
// counters; enable comes up zero, round_limit 16 and hold_rounds 7.
// When the receiver stalls, the result holds, the queue fills and then
// in_stall rises until the output moves again.
// ----------------------------------------------------------------------------
module incast_window_clamp_engine_core #(
	parameter int NUM_PORTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [3:0]  port,
	input  logic        is_tcp,
	input  logic        syn_flag,
	input  logic        fin_flag,
	input  logic        ack_flag,
	input  logic [15:0] window_in,
	input  logic [15:0] checksum_in,
	input  logic [23:0] backlog,
	input  logic        last_port,
	input  logic [23:0] queue_limit_in,
	input  logic [15:0] mtu_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] window_out,
	output logic [15:0] checksum_out,
	output logic        window_rewritten,
	output logic        incast_state,
	output logic        incast_detected,
	output logic        accepted,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	logic                 enable_q;
	logic [7:0]           round_limit_q;
	logic [7:0]           hold_rounds_q;
	iwce_pkg::item_t      in_item;
	iwce_pkg::item_t      q_item;
	iwce_pkg::result_t    res;
	logic                 q_valid;
	logic                 q_take;

	// Configuration registers.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q      <= 1'b0;
			round_limit_q <= 8'd16;
			hold_rounds_q <= 8'd7;
		end else if (cfg_valid) begin
			case (cfg_index)
				iwce_pkg::CFG_ENABLE:      enable_q      <= cfg_data[0];
				iwce_pkg::CFG_ROUND_LIMIT: round_limit_q <= cfg_data;
				iwce_pkg::CFG_HOLD_ROUNDS: hold_rounds_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Pack the input fields.
	always_comb begin
		in_item.req_type       = req_type;
		in_item.port           = port;
		in_item.is_tcp         = is_tcp;
		in_item.syn_flag       = syn_flag;
		in_item.fin_flag       = fin_flag;
		in_item.ack_flag       = ack_flag;
		in_item.window_in      = window_in;
		in_item.checksum_in    = checksum_in;
		in_item.backlog        = backlog;
		in_item.last_port      = last_port;
		in_item.queue_limit_in = queue_limit_in;
		in_item.mtu_in         = mtu_in;
	end

	iwce_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.q_valid  (q_valid),
		.q_take   (q_take),
		.q_item   (q_item)
	);

	iwce_back #(.NUM_PORTS(NUM_PORTS)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.enable      (enable_q),
		.round_limit (round_limit_q),
		.hold_rounds (hold_rounds_q),
		.q_valid     (q_valid),
		.q_take      (q_take),
		.q_item      (q_item),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_res     (res)
	);

	assign window_out       = res.window_out;
	assign checksum_out     = res.checksum_out;
	assign window_rewritten = res.window_rewritten;
	assign incast_state     = res.incast_state;
	assign incast_detected  = res.incast_detected;
	assign accepted         = res.accepted;

endmodule

[rtl/iwce_front.sv]
// ----------------------------------------------------------------------------
// iwce_front
// Input stage and two-entry queue that decouples acceptance from execution.
// ----------------------------------------------------------------------------
module iwce_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  iwce_pkg::item_t    in_item,
	output logic               q_valid,
	input  logic               q_take,
	output iwce_pkg::item_t    q_item
);

	iwce_pkg::item_t entry_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;
	logic            push;
	logic            pop;

	// The queue stalls the sender only when both entries are taken.
	assign in_stall = (count_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (count_q != 2'd0);
	assign pop      = q_valid && q_take;
	assign q_item   = entry_q[rd_ptr_q];

	// Entry storage holds payload only.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= in_item;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	`include "incast_window_clamp_engine_core_macros.svh"
	`IWC_ASSERT_IMP(a_no_overflow, clk, arst_n, count_q == 2'd2, !push)
	`IWC_ASSERT_IMP(a_no_underflow, clk, arst_n, count_q == 2'd0, !pop)
	`IWC_ASSERT_NEXT(a_count_hold, clk, arst_n, push && !pop && count_q == 2'd1,
		count_q == 2'd2)

endmodule

[rtl/iwce_back.sv]
// ----------------------------------------------------------------------------
// iwce_back
// Executes one item against the per-port tables, one item a cycle for
// packets and setups while the output is free; a tick waits for its product.
// ----------------------------------------------------------------------------
module iwce_back #(
	parameter int NUM_PORTS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               enable,
	input  logic [7:0]         round_limit,
	input  logic [7:0]         hold_rounds,
	input  logic               q_valid,
	output logic               q_take,
	input  iwce_pkg::item_t    q_item,
	output logic               out_valid,
	input  logic               out_stall,
	output iwce_pkg::result_t  out_res
);

	localparam int PW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

	logic [NUM_PORTS-1:0] port_valid_q;
	logic [NUM_PORTS-1:0] incast_flag_q;
	logic [23:0]          queue_limit_q [NUM_PORTS];
	logic [15:0]          segment_size_q [NUM_PORTS];
	logic [15:0]          syn_count_q [NUM_PORTS];
	logic [31:0]          start_round_q [NUM_PORTS];
	logic [7:0]           round_phase_q;
	logic [31:0]          round_number_q;

	logic                 phase_q;   // tick: product cycle done
	logic [40:0]          prod_q;
	logic                 res_valid_q;
	iwce_pkg::result_t    res_q;

	logic                 in_range;
	logic [PW-1:0]        pidx;
	logic                 pvalid;
	logic [23:0]          qlim;
	logic [15:0]          seg;
	logic [15:0]          syn;
	logic                 inc;
	logic [20:0]          wnd;
	logic [19:0]          lim10;
	logic [20:0]          mult_b;
	logic                 is_tick;
	logic                 do_exec;
	logic                 out_free;
	logic                 clear_ok;
	logic                 inc_after_clear;
	logic [41:0]          amount;
	logic                 set_inc;
	iwce_pkg::result_t    res_d;

	// Port decode.
	assign in_range = (32'(q_item.port) < NUM_PORTS);
	assign pidx     = in_range ? PW'(q_item.port) : '0;
	assign pvalid   = in_range && port_valid_q[pidx];
	assign qlim     = queue_limit_q[pidx];
	assign seg      = segment_size_q[pidx];
	assign syn      = syn_count_q[pidx];
	assign inc      = incast_flag_q[pidx];
	assign wnd      = 21'(qlim >> iwce_pkg::WND_SHIFT);
	assign lim10    = {seg, 3'b0} + {3'b0, seg, 1'b0};
	assign mult_b   = (wnd < {1'b0, lim10}) ? wnd : {1'b0, lim10};

	assign is_tick  = (q_item.req_type == iwce_pkg::REQ_TICK) && enable && pvalid;
	assign out_free = !res_valid_q || !out_stall;
	// A valid tick first registers its product, then executes.
	assign do_exec  = q_valid && out_free && (!is_tick || phase_q);
	assign q_take   = do_exec;

	// Tick decision.
	assign clear_ok = inc && ({8'b0, q_item.backlog} < 32'(wnd)) &&
		((round_number_q - start_round_q[pidx]) >= {24'b0, hold_rounds});
	assign inc_after_clear = inc && !clear_ok;
	assign amount   = {1'b0, prod_q} + {18'b0, q_item.backlog};
	assign set_inc  = !inc_after_clear && (amount > {18'b0, qlim}) &&
		(q_item.backlog != 24'd0);

	// Result formation.
	always_comb begin
		res_d = '0;
		case (q_item.req_type)
			iwce_pkg::REQ_PACKET: begin
				res_d.window_out   = q_item.window_in;
				res_d.checksum_out = q_item.checksum_in;
				if (enable && pvalid) begin
					res_d.accepted     = 1'b1;
					res_d.incast_state = inc;
					if (q_item.is_tcp && q_item.ack_flag && seg != 16'd0 &&
						(inc || ({1'b0, q_item.backlog} + {9'b0, seg}
						>= {1'b0, qlim}))) begin
						res_d.window_out       = seg;
						res_d.checksum_out     = iwce_pkg::csum_patch(q_item.checksum_in,
							q_item.window_in, seg);
						res_d.window_rewritten = 1'b1;
					end
				end
			end
			iwce_pkg::REQ_TICK: begin
				if (enable && pvalid) begin
					res_d.accepted        = 1'b1;
					res_d.incast_state    = inc_after_clear || set_inc;
					res_d.incast_detected = set_inc;
				end
			end
			iwce_pkg::REQ_SETUP: begin
				res_d.accepted = enable && in_range &&
					(q_item.queue_limit_in != 24'd0) && (q_item.mtu_in != 16'd0);
			end
			default: begin
				res_d = '0;
			end
		endcase
	end

	// Product register for the tick test.
	always_ff @(posedge clk) begin
		prod_q <= {25'b0, syn} * {20'b0, mult_b};
	end

	// Output register; the table update happens on execution.
	always_ff @(posedge clk) begin
		if (do_exec) res_q <= res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			phase_q     <= 1'b0;
		end else begin
			if (do_exec) res_valid_q <= 1'b1;
			else if (!out_stall) res_valid_q <= 1'b0;
			if (do_exec) phase_q <= 1'b0;
			else if (q_valid && is_tick && out_free) phase_q <= 1'b1;
		end
	end

	// Setup payload tables.
	always_ff @(posedge clk) begin
		if (do_exec && q_item.req_type == iwce_pkg::REQ_SETUP && res_d.accepted) begin
			queue_limit_q[pidx]  <= q_item.queue_limit_in;
			segment_size_q[pidx] <= (q_item.mtu_in > iwce_pkg::HDR_OVERHEAD) ?
				q_item.mtu_in - iwce_pkg::HDR_OVERHEAD : 16'd0;
		end
	end

	// Control state tables and round counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			port_valid_q   <= '0;
			incast_flag_q  <= '0;
			round_phase_q  <= 8'd0;
			round_number_q <= 32'd0;
			for (int i = 0; i < NUM_PORTS; i++) begin
				syn_count_q[i]   <= 16'd0;
				start_round_q[i] <= 32'd0;
			end
		end else if (do_exec && enable) begin
			case (q_item.req_type)
				iwce_pkg::REQ_PACKET: begin
					if (pvalid && q_item.is_tcp && !inc) begin
						if (q_item.syn_flag) begin
							if (syn != 16'hFFFF) syn_count_q[pidx] <= syn + 16'd1;
						end else if (q_item.fin_flag) begin
							if (syn != 16'd0) syn_count_q[pidx] <= syn - 16'd1;
						end
					end
				end
				iwce_pkg::REQ_TICK: begin
					if (pvalid) begin
						incast_flag_q[pidx] <= inc_after_clear || set_inc;
						if (set_inc) start_round_q[pidx] <= round_number_q;
						if (set_inc || round_phase_q == round_limit)
							syn_count_q[pidx] <= 16'd0;
					end
					if (q_item.last_port) begin
						round_phase_q  <= (round_phase_q == round_limit) ? 8'd0 :
							round_phase_q + 8'd1;
						round_number_q <= round_number_q + 32'd1;
					end
				end
				iwce_pkg::REQ_SETUP: begin
					if (res_d.accepted) begin
						port_valid_q[pidx]  <= 1'b1;
						incast_flag_q[pidx] <= 1'b0;
						syn_count_q[pidx]   <= 16'd0;
						start_round_q[pidx] <= 32'd0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign out_valid = res_valid_q;
	assign out_res   = res_q;

	`include "incast_window_clamp_engine_core_macros.svh"
	`IWC_ASSERT_IMP(a_take_needs_room, clk, arst_n, q_take, out_free && q_valid)
	`IWC_ASSERT_IMP(a_detect_sets, clk, arst_n, do_exec && res_d.incast_detected,
		res_d.incast_state)
	`IWC_ASSERT_NEXT(a_exec_gives_result, clk, arst_n, do_exec, res_valid_q)

endmodule
